// ----- hw/rtl/lrupr_pkg.sv -----
// Shared types and constants for the LRU page replacement unit.
`timescale 1ns / 1ps

package lrupr_pkg;

	localparam int unsigned FRAMES_DEF    = 16;
	localparam int unsigned PAGE_BITS_DEF = 16;
	localparam int unsigned CFG_W         = 5;
	localparam int unsigned SLOT_W        = 4;
	localparam int unsigned COUNT_W       = 16;

	localparam logic [CFG_W-1:0]   CFG_RESET = CFG_W'(16);
	localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

	// Flags of the search token that walks the row of frame cells.
	typedef struct packed {
		logic vld;
		logic hit;
		logic empty;
	} tok_flags_t;

	// Update broadcast to every frame cell once the search has finished.
	typedef struct packed {
		logic en;
		logic clear;
		logic write;
		logic age_all;
	} upd_ctl_t;

endpackage

// ----- hw/rtl/lru_page_replacement.sv -----
// Top level of the LRU page replacement unit: request control, frame row and result registers.
//
//  channel   direction  handshake                     payload
//  request   in         start, busy                   page_number, end_of_sequence
//  result    out        done (one-cycle strobe)       fault, frame_slot, evicted_valid,
//                                                     evicted_page, fault_total
//  config    in         cfg_we                        cfg_wdata (frames_in_use)
//
// A request is carried from acceptance to its done strobe by a search token that steps
// through the row of frame cells one cell per cycle; as the token leaves the last cell
// the frames are updated and the result is registered.
// busy is high from acceptance until the result is registered; the next request may be
// accepted in the cycle done is high. The result cannot be stalled.
// Reset empties all frames at once, clears the running fault count and sets frames_in_use to 16.
`timescale 1ns / 1ps

module lru_page_replacement #(
	parameter int unsigned FRAMES    = lrupr_pkg::FRAMES_DEF,
	parameter int unsigned PAGE_BITS = lrupr_pkg::PAGE_BITS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	output logic                           busy,
	input  logic [PAGE_BITS-1:0]           page_number,
	input  logic                           end_of_sequence,
	input  logic                           cfg_we,
	input  logic [lrupr_pkg::CFG_W-1:0]    cfg_wdata,
	output logic                           done,
	output logic                           fault,
	output logic [lrupr_pkg::SLOT_W-1:0]   frame_slot,
	output logic                           evicted_valid,
	output logic [PAGE_BITS-1:0]           evicted_page,
	output logic [lrupr_pkg::COUNT_W-1:0]  fault_total
);
	import lrupr_pkg::*;

	localparam int unsigned IDX_W = (FRAMES > 1) ? $clog2(FRAMES) : 1;

	logic [CFG_W-1:0]     frames_in_use_q;
	logic                 busy_q;
	logic                 inj_vld_q;
	logic [PAGE_BITS-1:0] inj_page_q;
	logic                 eos_q;
	logic [COUNT_W-1:0]   count_q;

	logic                 done_q;
	logic                 fault_q;
	logic [SLOT_W-1:0]    slot_q;
	logic                 ev_valid_q;
	logic [PAGE_BITS-1:0] ev_page_q;
	logic [COUNT_W-1:0]   total_q;

	tok_flags_t           fl       [FRAMES+1];
	logic [PAGE_BITS-1:0] pg       [FRAMES+1];
	logic [IDX_W-1:0]     hit_idx  [FRAMES+1];
	logic [IDX_W-1:0]     hit_rank [FRAMES+1];
	logic [IDX_W-1:0]     emp_idx  [FRAMES+1];
	logic [IDX_W-1:0]     max_idx  [FRAMES+1];
	logic [IDX_W-1:0]     max_rank [FRAMES+1];
	logic [PAGE_BITS-1:0] max_page [FRAMES+1];
	logic [FRAMES-1:0]    in_use;
	logic [FRAMES:0]      tok_vld;

	upd_ctl_t             upd;
	logic [IDX_W-1:0]     upd_slot;
	logic [IDX_W-1:0]     upd_rank;
	logic                 miss;
	logic                 evict;
	logic [COUNT_W-1:0]   count_next;
	logic [IDX_W+SLOT_W-1:0] slot_ext;
	logic                 accept;
	logic                 finish;

	assign accept = start && !busy_q;
	assign finish = tok_vld[FRAMES];

	assign fl[0]       = '{vld: inj_vld_q, hit: 1'b0, empty: 1'b0};
	assign pg[0]       = inj_page_q;
	assign hit_idx[0]  = '0;
	assign hit_rank[0] = '0;
	assign emp_idx[0]  = '0;
	assign max_idx[0]  = '0;
	assign max_rank[0] = '0;
	assign max_page[0] = '0;

	genvar i;
	generate
		for (i = 0; i < FRAMES; i++) begin : g_cell
			// A setting of zero still keeps frame 0 in use.
			assign in_use[i] = (i == 0) || (32'(frames_in_use_q) > 32'(i));

			lrupr_cell #(
				.FRAMES    (FRAMES),
				.PAGE_BITS (PAGE_BITS),
				.IDX       (i)
			) u_cell (
				.clk           (clk),
				.arst_n        (arst_n),
				.in_use        (in_use[i]),
				.flags_in      (fl[i]),
				.page_in       (pg[i]),
				.hit_idx_in    (hit_idx[i]),
				.hit_rank_in   (hit_rank[i]),
				.empty_idx_in  (emp_idx[i]),
				.max_idx_in    (max_idx[i]),
				.max_rank_in   (max_rank[i]),
				.max_page_in   (max_page[i]),
				.flags_out     (fl[i+1]),
				.page_out      (pg[i+1]),
				.hit_idx_out   (hit_idx[i+1]),
				.hit_rank_out  (hit_rank[i+1]),
				.empty_idx_out (emp_idx[i+1]),
				.max_idx_out   (max_idx[i+1]),
				.max_rank_out  (max_rank[i+1]),
				.max_page_out  (max_page[i+1]),
				.upd           (upd),
				.upd_slot      (upd_slot),
				.upd_rank      (upd_rank),
				.upd_page      (pg[FRAMES])
			);
		end
		for (i = 0; i <= FRAMES; i++) begin : g_vld
			assign tok_vld[i] = fl[i].vld;
		end
	endgenerate

	// Decision taken from the token as it leaves the last cell.
	always_comb begin
		miss  = !fl[FRAMES].hit;
		evict = miss && !fl[FRAMES].empty;
		if (!miss) begin
			upd_slot = hit_idx[FRAMES];
		end else if (!evict) begin
			upd_slot = emp_idx[FRAMES];
		end else begin
			upd_slot = max_idx[FRAMES];
		end
		upd_rank    = miss ? max_rank[FRAMES] : hit_rank[FRAMES];
		upd.en      = finish;
		upd.clear   = eos_q;
		upd.write   = miss;
		upd.age_all = miss && !evict;
		if (miss && (count_q != COUNT_MAX)) begin
			count_next = count_q + COUNT_W'(1);
		end else begin
			count_next = count_q;
		end
		slot_ext = {{SLOT_W{1'b0}}, upd_slot};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frames_in_use_q <= CFG_RESET;
			busy_q          <= 1'b0;
			inj_vld_q       <= 1'b0;
			count_q         <= '0;
			done_q          <= 1'b0;
		end else begin
			if (cfg_we) begin
				frames_in_use_q <= cfg_wdata;
			end
			inj_vld_q <= accept;
			done_q    <= finish;
			if (accept) begin
				busy_q <= 1'b1;
			end else if (finish) begin
				busy_q <= 1'b0;
			end
			if (finish) begin
				count_q <= eos_q ? '0 : count_next;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			inj_page_q <= page_number;
			eos_q      <= end_of_sequence;
		end
		if (finish) begin
			fault_q    <= miss;
			slot_q     <= slot_ext[SLOT_W-1:0];
			ev_valid_q <= evict;
			ev_page_q  <= evict ? max_page[FRAMES] : '0;
			total_q    <= count_next;
		end
	end

	assign busy          = busy_q;
	assign done          = done_q;
	assign fault         = fault_q;
	assign frame_slot    = slot_q;
	assign evicted_valid = ev_valid_q;
	assign evicted_page  = ev_page_q;
	assign fault_total   = total_q;

`ifndef SYNTHESIS
	// Only one request is ever in flight along the row.
	a_one_token: assert property (@(posedge clk) disable iff (!arst_n) $onehot0(tok_vld))
		else $error("more than one search token in the frame row");
	// A token in the row always belongs to an accepted request.
	a_token_busy: assert property (@(posedge clk) disable iff (!arst_n) (|tok_vld) |-> busy_q)
		else $error("search token present while idle");
	// The result strobe follows the end of the busy period.
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n) done |-> !busy_q)
		else $error("result strobe while still busy");
	// A replacement only happens on a page fault.
	a_evict_fault: assert property (@(posedge clk) disable iff (!arst_n)
		(done && evicted_valid) |-> fault)
		else $error("eviction reported on a hit");
	// An accepted request enters the row in the next cycle.
	a_inject: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (busy_q && tok_vld[0]))
		else $error("accepted request did not enter the frame row");
`endif

endmodule

// ----- hw/rtl/lrupr_cell.sv -----
// One page frame: its page, valid bit and recency rank, plus one stage of the search token.
`timescale 1ns / 1ps

module lrupr_cell #(
	parameter int unsigned FRAMES    = 16,
	parameter int unsigned PAGE_BITS = 16,
	parameter int unsigned IDX       = 0,
	localparam int unsigned IDX_W    = (FRAMES > 1) ? $clog2(FRAMES) : 1
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_use,
	input  lrupr_pkg::tok_flags_t  flags_in,
	input  logic [PAGE_BITS-1:0]   page_in,
	input  logic [IDX_W-1:0]       hit_idx_in,
	input  logic [IDX_W-1:0]       hit_rank_in,
	input  logic [IDX_W-1:0]       empty_idx_in,
	input  logic [IDX_W-1:0]       max_idx_in,
	input  logic [IDX_W-1:0]       max_rank_in,
	input  logic [PAGE_BITS-1:0]   max_page_in,
	output lrupr_pkg::tok_flags_t  flags_out,
	output logic [PAGE_BITS-1:0]   page_out,
	output logic [IDX_W-1:0]       hit_idx_out,
	output logic [IDX_W-1:0]       hit_rank_out,
	output logic [IDX_W-1:0]       empty_idx_out,
	output logic [IDX_W-1:0]       max_idx_out,
	output logic [IDX_W-1:0]       max_rank_out,
	output logic [PAGE_BITS-1:0]   max_page_out,
	input  lrupr_pkg::upd_ctl_t    upd,
	input  logic [IDX_W-1:0]       upd_slot,
	input  logic [IDX_W-1:0]       upd_rank,
	input  logic [PAGE_BITS-1:0]   upd_page
);
	import lrupr_pkg::*;

	localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(IDX);

	logic [PAGE_BITS-1:0] page_q;
	logic                 valid_q;
	logic [IDX_W-1:0]     rank_q;

	tok_flags_t           flags_q;
	logic [PAGE_BITS-1:0] tpage_q;
	logic [IDX_W-1:0]     hit_idx_q;
	logic [IDX_W-1:0]     hit_rank_q;
	logic [IDX_W-1:0]     empty_idx_q;
	logic [IDX_W-1:0]     max_idx_q;
	logic [IDX_W-1:0]     max_rank_q;
	logic [PAGE_BITS-1:0] max_page_q;

	logic match;
	logic empty_here;
	logic take_max;

	// The first matching frame wins, so a token that already hit passes unchanged.
	assign match      = in_use && valid_q && !flags_in.hit && (page_q == page_in);
	assign empty_here = in_use && !valid_q && !flags_in.empty;
	assign take_max   = in_use && ((MY_IDX == '0) || (rank_q > max_rank_in));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flags_q <= '0;
		end else begin
			flags_q.vld   <= flags_in.vld;
			flags_q.hit   <= flags_in.hit || match;
			flags_q.empty <= flags_in.empty || empty_here;
		end
	end

	always_ff @(posedge clk) begin
		tpage_q     <= page_in;
		hit_idx_q   <= match ? MY_IDX : hit_idx_in;
		hit_rank_q  <= match ? rank_q : hit_rank_in;
		empty_idx_q <= empty_here ? MY_IDX : empty_idx_in;
		max_idx_q   <= take_max ? MY_IDX : max_idx_in;
		max_rank_q  <= take_max ? rank_q : max_rank_in;
		max_page_q  <= take_max ? page_q : max_page_in;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			rank_q  <= '0;
		end else if (upd.en) begin
			if (upd.clear) begin
				valid_q <= 1'b0;
				rank_q  <= '0;
			end else if (upd_slot == MY_IDX) begin
				rank_q <= '0;
				if (upd.write) begin
					valid_q <= 1'b1;
				end
			end else if (valid_q && (upd.age_all || (rank_q < upd_rank))) begin
				// Ranks of valid frames stay a permutation, so this never wraps.
				rank_q <= rank_q + IDX_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (upd.en && upd.write && (upd_slot == MY_IDX)) begin
			page_q <= upd_page;
		end
	end

	assign flags_out     = flags_q;
	assign page_out      = tpage_q;
	assign hit_idx_out   = hit_idx_q;
	assign hit_rank_out  = hit_rank_q;
	assign empty_idx_out = empty_idx_q;
	assign max_idx_out   = max_idx_q;
	assign max_rank_out  = max_rank_q;
	assign max_page_out  = max_page_q;

endmodule

// ----- tb/tb_lru_page_replacement.sv -----
// Self-checking testbench for the LRU page replacement unit with a built-in frame predictor.
`timescale 1ns / 1ps

module tb_lru_page_replacement;
	import lrupr_pkg::*;

	localparam int NF    = FRAMES_DEF;
	localparam int PW    = PAGE_BITS_DEF;
	localparam int LIMIT = 300000;

	logic                clk;
	logic                arst_n;
	logic                start;
	logic                busy;
	logic [PW-1:0]       page_number;
	logic                end_of_sequence;
	logic                cfg_we;
	logic [CFG_W-1:0]    cfg_wdata;
	logic                done;
	logic                fault;
	logic [SLOT_W-1:0]   frame_slot;
	logic                evicted_valid;
	logic [PW-1:0]       evicted_page;
	logic [COUNT_W-1:0]  fault_total;

	typedef struct packed {
		logic                fault;
		logic [SLOT_W-1:0]   slot;
		logic                ev_valid;
		logic [PW-1:0]       ev_page;
		logic [COUNT_W-1:0]  total;
	} lookup_t;

	// Tracks frame contents and recency, and holds the lookups still owed by the block.
	class lru_frame_tracker;
		logic [PW-1:0]      page_of[NF];
		bit                 held[NF];
		bit [7:0]           rank[NF];
		logic [COUNT_W-1:0] faults;
		bit [CFG_W-1:0]     frames_cfg;
		lookup_t            expected_lookups[$];
		int                 errors;
		int                 results;
		int                 hits;
		int                 evictions;

		function new();
			clear_frames();
			frames_cfg = CFG_RESET;
		endfunction

		function void clear_frames();
			foreach (page_of[i]) begin
				page_of[i] = '0;
				held[i] = 1'b0;
				rank[i] = '0;
			end
			faults = '0;
		endfunction

		// Frame k becomes the most recent; every held frame newer than old_rank ages.
		function void promote(int k, int old_rank);
			foreach (rank[i]) begin
				if (i != k && held[i] && rank[i] < old_rank && rank[i] < 8'd255)
					rank[i]++;
			end
			rank[k] = '0;
		endfunction

		function void note_request(logic [PW-1:0] pg, logic eos);
			lookup_t want;
			int      n;
			int      slot;
			bit      hit;
			bit      empty_found;
			n = frames_cfg;
			slot = 0;
			hit = 0;
			empty_found = 0;
			want = '0;
			if (n < 1) n = 1;
			if (n > NF) n = NF;
			for (int i = 0; i < n; i++) begin
				if (held[i] && page_of[i] == pg) begin
					hit = 1;
					slot = i;
					break;
				end
			end
			if (hit) begin
				promote(slot, rank[slot]);
				hits++;
			end else begin
				for (int i = 0; i < n; i++) begin
					if (!held[i]) begin
						empty_found = 1;
						slot = i;
						break;
					end
				end
				if (empty_found) begin
					// A fresh frame counts as older than everything, so all held frames age.
					promote(slot, 256);
				end else begin
					slot = 0;
					for (int i = 1; i < n; i++) begin
						if (rank[i] > rank[slot])
							slot = i;
					end
					want.ev_valid = 1'b1;
					want.ev_page = page_of[slot];
					evictions++;
					promote(slot, rank[slot]);
				end
				page_of[slot] = pg;
				held[slot] = 1'b1;
				if (faults != COUNT_MAX)
					faults++;
			end
			want.fault = !hit;
			want.slot = slot[SLOT_W-1:0];
			want.total = faults;
			expected_lookups.push_back(want);
			if (eos)
				clear_frames();
		endfunction

		function void check_result(lookup_t got);
			lookup_t want;
			if (expected_lookups.size() == 0) begin
				$error("result with no request outstanding");
				errors++;
				return;
			end
			want = expected_lookups.pop_front();
			results++;
			if (got.fault !== want.fault) begin
				$error("fault: expected %0d, actual %0d", want.fault, got.fault);
				errors++;
			end
			if (got.slot !== want.slot) begin
				$error("frame_slot: expected %0d, actual %0d", want.slot, got.slot);
				errors++;
			end
			if (got.ev_valid !== want.ev_valid) begin
				$error("evicted_valid: expected %0d, actual %0d", want.ev_valid, got.ev_valid);
				errors++;
			end
			if (got.ev_page !== want.ev_page) begin
				$error("evicted_page: expected 0x%h, actual 0x%h", want.ev_page, got.ev_page);
				errors++;
			end
			if (got.total !== want.total) begin
				$error("fault_total: expected %0d, actual %0d", want.total, got.total);
				errors++;
			end
		endfunction

		function int pending();
			return expected_lookups.size();
		endfunction
	endclass

	lru_frame_tracker board = new();
	int cycles = 0;

	lru_page_replacement #(
		.FRAMES(NF),
		.PAGE_BITS(PW)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.page_number(page_number),
		.end_of_sequence(end_of_sequence),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.done(done),
		.fault(fault),
		.frame_slot(frame_slot),
		.evicted_valid(evicted_valid),
		.evicted_page(evicted_page),
		.fault_total(fault_total)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == LIMIT) begin
			$display("tb_lru_page_replacement failed");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && done === 1'b1)
			board.check_result({fault, frame_slot, evicted_valid, evicted_page, fault_total});
	end

	// Holds start high until the transaction is taken; start stays high afterwards.
	task automatic issue_request(input logic [PW-1:0] pg, input logic eos);
		@(negedge clk);
		start <= 1'b1;
		page_number <= pg;
		end_of_sequence <= eos;
		do @(posedge clk); while (busy);
		board.note_request(pg, eos);
	endtask

	task automatic pause_requests(input int n);
		if (n > 0) begin
			@(negedge clk);
			start <= 1'b0;
			repeat (n - 1) @(negedge clk);
		end
	endtask

	task automatic wait_all_answered();
		@(negedge clk);
		start <= 1'b0;
		while (board.pending() != 0) @(posedge clk);
	endtask

	task automatic write_frames(input logic [CFG_W-1:0] value);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		@(negedge clk);
		cfg_we <= 1'b0;
		board.frames_cfg = value;
	endtask

	initial begin
		logic [PW-1:0]    pool[24];
		logic [PW-1:0]    pg;
		logic [CFG_W-1:0] phase_cfg[6];
		int               n_eff;
		int               pool_size;
		int               seq_len;
		int               issued;
		int               mode;
		int               gap;
		int               sequences;
		bit               burst;
		bit               eos;

		sequences = 0;
		arst_n = 1'b0;
		start = 1'b0;
		page_number = '0;
		end_of_sequence = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Extreme page numbers, hits and a sequence end on a hit.
		write_frames(5'd16);
		issue_request('0, 1'b0);
		issue_request('1, 1'b0);
		issue_request('0, 1'b0);
		issue_request('1, 1'b1);

		// Four frames: fill, evict the oldest, refresh one, evict again.
		wait_all_answered();
		write_frames(5'd4);
		issue_request(16'd10, 1'b0);
		issue_request(16'd11, 1'b0);
		issue_request(16'd12, 1'b0);
		issue_request(16'd13, 1'b0);
		pause_requests(3);
		issue_request(16'd14, 1'b0);
		issue_request(16'd11, 1'b0);
		issue_request(16'd15, 1'b0);

		// Shrinking to one frame leaves a copy of page 13 in frame 3 while frame 0 takes it.
		wait_all_answered();
		write_frames(5'd1);
		issue_request(16'd13, 1'b0);
		wait_all_answered();
		write_frames(5'd4);
		issue_request(16'd13, 1'b0);
		issue_request(16'hA5A5, 1'b1);

		// A setting of zero behaves as one frame.
		wait_all_answered();
		write_frames(5'd0);
		issue_request(16'd7, 1'b0);
		issue_request(16'd7, 1'b0);
		issue_request(16'd8, 1'b1);

		// Settings above the frame count behave as the full row.
		wait_all_answered();
		write_frames(5'd31);
		issue_request(16'h8000, 1'b0);
		issue_request(16'h7FFF, 1'b1);

		phase_cfg[0] = 5'd16;
		phase_cfg[1] = 5'd1;
		phase_cfg[2] = 5'd17;
		phase_cfg[3] = CFG_W'($urandom_range(2, 15));
		phase_cfg[4] = CFG_W'($urandom_range(0, 31));
		phase_cfg[5] = 5'd3;

		// Each phase runs access sequences over a small working set, with some noise.
		for (int p = 0; p < 6; p++) begin
			wait_all_answered();
			write_frames(phase_cfg[p]);
			n_eff = (phase_cfg[p] < 1) ? 1 : (phase_cfg[p] > NF) ? NF : phase_cfg[p];
			issued = 0;
			while (issued < 100) begin
				seq_len = $urandom_range(3, 40);
				pool_size = $urandom_range(1, n_eff + 4);
				for (int j = 0; j < pool_size; j++)
					pool[j] = PW'($urandom());
				burst = ($urandom_range(0, 3) == 0);
				sequences++;
				for (int i = 0; i < seq_len && issued < 100; i++) begin
					mode = $urandom_range(0, 99);
					if (mode < 80)
						pg = pool[$urandom_range(0, pool_size - 1)];
					else if (mode < 94)
						pg = PW'($urandom());
					else
						pg = mode[0] ? '1 : '0;
					eos = (i == seq_len - 1) || ($urandom_range(0, 49) == 0);
					issue_request(pg, eos);
					issued++;
					if (!burst) begin
						mode = $urandom_range(0, 99);
						if (mode < 55)
							gap = 0;
						else if (mode < 90)
							gap = $urandom_range(1, 3);
						else
							gap = $urandom_range(8, 40);
						pause_requests(gap);
					end
					if ($urandom_range(0, 39) == 0)
						wait_all_answered();
				end
			end
		end

		wait_all_answered();
		repeat (NF + 4) @(posedge clk);
		if (board.pending() != 0) begin
			$error("%0d expected results never arrived", board.pending());
			board.errors++;
		end
		$display("Checked %0d lookups over %0d random access sequences and the directed cases.",
			board.results, sequences);
		$display("They included %0d hits and %0d evictions, with frame settings from 0 to 31.",
			board.hits, board.evictions);
		if (board.errors == 0)
			$display("tb_lru_page_replacement passed");
		else
			$display("tb_lru_page_replacement failed");
		$finish;
	end

endmodule
